/* rtl/pixnorm_pkg.sv */
// Shared types, constants and helpers of the pixel normaliser.
package pixnorm_pkg;

  localparam int BYTE_W     = 8;
  localparam int NUM_BYTES  = 4;
  localparam int VALUE_W    = 32;
  localparam int DEST_W     = 24;
  localparam int PLANE_W    = 2;
  localparam int PROD_W     = 41;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_CHAN_W = 3;
  localparam int CFG_SIDE_W = 12;
  localparam int SIDE_LIMIT = 4095;

  localparam logic [CFG_CHAN_W-1:0] CHAN_RESET         = 3'd3;
  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET         = 12'd1;
  localparam logic [CFG_DATA_W-1:0] NORM_RESET         = 64'h0000_0101_0000_0000;
  localparam logic [CFG_CHAN_W-1:0] SRC_CHANNELS_MAX   = 3'd4;
  localparam logic [CFG_CHAN_W-1:0] SRC_CHANNELS_UNSUP = 3'd2;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TENSOR_CHANNELS,
    REG_SOURCE_CHANNELS,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_NORM_CHAN0,
    REG_NORM_CHAN1,
    REG_NORM_CHAN2,
    REG_NORM_CHAN3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte0;
    logic [BYTE_W-1:0] pixel_byte1;
    logic [BYTE_W-1:0] pixel_byte2;
    logic [BYTE_W-1:0] pixel_byte3;
  } pix_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] norm_value;
    logic [DEST_W-1:0]         dest_index;
    logic [PLANE_W-1:0]        plane;
    logic                      last_in_pixel;
    logic                      last_in_image;
    logic                      status;
  } result_t;

  // Load enables of the two register stages inside each lane.
  typedef struct packed {
    logic load_mul;
    logic load_sum;
  } lane_ctl_t;

  // Per-pixel information that travels alongside the lanes.
  typedef struct packed {
    logic bad;
    logic last_img;
  } pix_meta_t;

  function automatic logic [BYTE_W-1:0] byte_of(input pix_t pix, input logic [1:0] sel);
    logic [BYTE_W-1:0] b;
    case (sel)
      2'd0:    b = pix.pixel_byte0;
      2'd1:    b = pix.pixel_byte1;
      2'd2:    b = pix.pixel_byte2;
      default: b = pix.pixel_byte3;
    endcase
    return b;
  endfunction

endpackage

/* rtl/pixnorm_in_if.sv */
// Pixel input channel: valid/ready handshake carrying one interleaved pixel.
interface pixnorm_in_if import pixnorm_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/pixnorm_out_if.sv */
// Result output channel: valid/ready handshake carrying one normalised value.
interface pixnorm_out_if import pixnorm_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/pixnorm_lane.sv */
// One channel lane: byte times scale, then offset add, saturation and destination index.
module pixnorm_lane import pixnorm_pkg::*; #(
  parameter int LANE    = 0,
  parameter int COUNT_W = 22,
  parameter int POS_W   = 22
) (
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic [BYTE_W-1:0]         pix_byte,
  input  logic [CFG_DATA_W-1:0]     norm,
  input  logic [COUNT_W-1:0]        count,
  input  logic [POS_W-1:0]          pos,
  output logic signed [VALUE_W-1:0] value,
  output logic [DEST_W-1:0]         dest
);

  localparam int IDX_SUM_W = COUNT_W + 3;

  logic signed [BYTE_W:0]      byte_s;
  logic signed [VALUE_W-1:0]   scale;
  logic signed [VALUE_W-1:0]   offset;
  logic signed [PROD_W-1:0]    prod_next;
  logic signed [PROD_W-1:0]    prod;
  logic [IDX_SUM_W-1:0]        idx_sum;
  logic [DEST_W-1:0]           dest_mul;
  logic signed [SUM_W-1:0]     sum;
  logic signed [VALUE_W-1:0]   value_next;

  assign byte_s    = $signed({1'b0, pix_byte});
  assign scale     = $signed(norm[2*VALUE_W-1:VALUE_W]);
  assign offset    = $signed(norm[VALUE_W-1:0]);
  assign prod_next = PROD_W'(byte_s) * PROD_W'(scale);
  assign idx_sum   = IDX_SUM_W'(LANE) * IDX_SUM_W'(count) + IDX_SUM_W'(pos);

  assign sum = SUM_W'(prod) + SUM_W'(offset);

  // The sum fits when every bit above the Q16.16 sign bit copies it.
  always_comb begin
    if (&sum[SUM_W-1:VALUE_W-1] || ~|sum[SUM_W-1:VALUE_W-1]) begin
      value_next = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      value_next = VALUE_MIN;
    end else begin
      value_next = VALUE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      prod     <= prod_next;
      dest_mul <= DEST_W'(idx_sum);
    end
    if (ctl.load_sum) begin
      value <= value_next;
      dest  <= dest_mul;
    end
  end

endmodule

/* rtl/pixnorm_merge.sv */
// Merge stage: walks the lane results of one pixel onto the result port.
module pixnorm_merge import pixnorm_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int LANE_W       = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s3_valid,
  input  pix_meta_t                 meta,
  input  logic [LANE_W-1:0]         k_last,
  input  logic signed [VALUE_W-1:0] value [MAX_CHANNELS],
  input  logic [DEST_W-1:0]         dest [MAX_CHANNELS],
  output logic                      s3_done,
  pixnorm_out_if.source             result_out
);

  logic [LANE_W-1:0] k;
  logic              load_out;
  result_t           res_next;

  assign load_out = s3_valid && (!result_out.valid || result_out.ready);
  assign s3_done  = load_out && (k == k_last);

  always_comb begin
    res_next.norm_value    = meta.bad ? '0 : value[k];
    res_next.dest_index    = dest[k];
    res_next.plane         = meta.bad ? '0 : PLANE_W'(k);
    res_next.last_in_pixel = (k == k_last);
    res_next.last_in_image = meta.last_img;
    res_next.status        = meta.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k                <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (load_out) begin
        result_out.valid <= 1'b1;
        k                <= s3_done ? '0 : k + LANE_W'(1);
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_out.data <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> k <= k_last)
    else $error("merge lane select beyond the pixel's last channel");
  a_done_rewinds: assert property (@(posedge clk) disable iff (rst)
    s3_done |=> k == '0)
    else $error("lane select not rewound after the pixel's last beat");
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.data.status |->
      result_out.data.last_in_pixel && result_out.data.plane == '0 &&
      result_out.data.norm_value == '0)
    else $error("error beat is not a single zero beat on plane zero");
`endif

endmodule

/* rtl/pixel_normalize_hwc_to_chw_top.sv */
// Pixel normaliser top level: configuration, pixel counter, lanes and merge.
//
// Usage: pixel_in takes one interleaved pixel (up to four bytes) per beat in
// raster order. For each of the first tensor_channels channels a beat leaves
// result_out carrying byte*scale+offset in saturated signed Q16.16 and its
// planar destination index channel*width*height+pixel_index, channels in
// ascending order. An invalid channel setting gives one error beat per pixel.
// Registers are written through cfg_write/cfg_index/cfg_data; the user writes
// them only while the block holds no pixel, which the block does not enforce;
// a write takes effect at the next edge. A pixel's results pass the input
// register, then multiply, offset and saturate, then the output register.
// The single result port, which the merge stage walks one lane per cycle while
// result_out is not stalled, sets the pace: a pixel leaves as tensor_channels
// beats (one on error), and a new pixel is taken while the previous one is
// still being sent.
// Reset (synchronous, rst high) empties the pipeline, zeroes the pixel
// counter and loads the register defaults. When result_out is stalled the
// output register holds, the pipeline fills and pixel_in.ready falls.
module pixel_normalize_hwc_to_chw_top import pixnorm_pkg::*; #(
  parameter int MAX_SIDE     = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pixnorm_in_if.sink            pixel_in,
  pixnorm_out_if.source         result_out
);

  localparam int SIDE_CAP = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
  localparam int SIDE_W   = $clog2(SIDE_CAP + 1);
  localparam int COUNT_W  = 2 * SIDE_W;
  localparam int POS_W    = (SIDE_CAP > 1) ? $clog2(SIDE_CAP * SIDE_CAP) : 1;
  localparam int LANE_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [CFG_CHAN_W-1:0] tensor_channels;
  logic [CFG_CHAN_W-1:0] source_channels;
  logic [CFG_SIDE_W-1:0] image_width;
  logic [CFG_SIDE_W-1:0] image_height;
  logic [CFG_DATA_W-1:0] norm_chan [MAX_CHANNELS];
  logic [POS_W-1:0]      pixel_position;

  logic [SIDE_W-1:0]  side_w;
  logic [SIDE_W-1:0]  side_h;
  logic [COUNT_W-1:0] count;
  logic [POS_W-1:0]   pos_eff;
  logic [COUNT_W-1:0] pos_inc;
  logic               bad;
  logic               accept;

  logic               s1_valid;
  pix_t               s1_pix;
  logic [POS_W-1:0]   s1_pos;
  logic [COUNT_W-1:0] s1_count;
  pix_meta_t          s1_meta;
  logic [LANE_W-1:0]  s1_k_last;
  logic               s2_valid;
  pix_meta_t          s2_meta;
  logic [LANE_W-1:0]  s2_k_last;
  logic               s3_valid;
  pix_meta_t          s3_meta;
  logic [LANE_W-1:0]  s3_k_last;

  logic               s2_load;
  logic               s3_load;
  logic               s3_done;
  lane_ctl_t          lane_ctl;

  logic signed [VALUE_W-1:0] lane_value [MAX_CHANNELS];
  logic [DEST_W-1:0]         lane_dest [MAX_CHANNELS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_channels <= CHAN_RESET;
      source_channels <= CHAN_RESET;
      image_width     <= SIDE_RESET;
      image_height    <= SIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_TENSOR_CHANNELS: tensor_channels <= cfg_data[CFG_CHAN_W-1:0];
        REG_SOURCE_CHANNELS: source_channels <= cfg_data[CFG_CHAN_W-1:0];
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[CFG_SIDE_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[CFG_SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_norm
    always_ff @(posedge clk) begin
      if (rst) begin
        norm_chan[l] <= NORM_RESET;
      end else if (cfg_write &&
                   cfg_index == CFG_IDX_W'(REG_NORM_CHAN0) + CFG_IDX_W'(l)) begin
        norm_chan[l] <= cfg_data;
      end
    end
  end

  // Image size with zero read as one and oversize clamped.
  always_comb begin
    if (image_width == '0) begin
      side_w = SIDE_W'(1);
    end else if (image_width > CFG_SIDE_W'(SIDE_CAP)) begin
      side_w = SIDE_W'(SIDE_CAP);
    end else begin
      side_w = SIDE_W'(image_width);
    end
    if (image_height == '0) begin
      side_h = SIDE_W'(1);
    end else if (image_height > CFG_SIDE_W'(SIDE_CAP)) begin
      side_h = SIDE_W'(SIDE_CAP);
    end else begin
      side_h = SIDE_W'(image_height);
    end
  end

  assign count = COUNT_W'(side_w) * COUNT_W'(side_h);

  // A counter left beyond a shrunken image restarts at the first pixel.
  assign pos_eff = (COUNT_W'(pixel_position) >= count) ? '0 : pixel_position;
  assign pos_inc = COUNT_W'(pos_eff) + COUNT_W'(1);

  assign bad = tensor_channels == '0 ||
               tensor_channels > CFG_CHAN_W'(MAX_CHANNELS) ||
               source_channels == '0 ||
               source_channels > SRC_CHANNELS_MAX ||
               source_channels == SRC_CHANNELS_UNSUP ||
               tensor_channels > source_channels;

  // Pipeline control: each stage moves on when the next one is free or leaving.
  assign s3_load        = s2_valid && (!s3_valid || s3_done);
  assign s2_load        = s1_valid && (!s2_valid || s3_load);
  assign pixel_in.ready = !s1_valid || s2_load;
  assign accept         = pixel_in.valid && pixel_in.ready;

  assign lane_ctl.load_mul = s2_load;
  assign lane_ctl.load_sum = s3_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
    end else begin
      if (accept) begin
        pixel_position <= (pos_inc >= count) ? '0 : POS_W'(pos_inc);
        s1_valid       <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s3_load) begin
        s2_valid <= 1'b0;
      end
      if (s3_load) begin
        s3_valid <= 1'b1;
      end else if (s3_done) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix            <= pixel_in.data;
      s1_pos            <= pos_eff;
      s1_count          <= count;
      s1_meta.bad       <= bad;
      s1_meta.last_img  <= (COUNT_W'(pos_eff) == count - COUNT_W'(1));
      s1_k_last         <= bad ? '0 : LANE_W'(tensor_channels - CFG_CHAN_W'(1));
    end
    if (s2_load) begin
      s2_meta   <= s1_meta;
      s2_k_last <= s1_k_last;
    end
    if (s3_load) begin
      s3_meta   <= s2_meta;
      s3_k_last <= s2_k_last;
    end
  end

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    pixnorm_lane #(
      .LANE    (l),
      .COUNT_W (COUNT_W),
      .POS_W   (POS_W)
    ) u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .pix_byte (byte_of(s1_pix, 2'(l))),
      .norm     (norm_chan[l]),
      .count    (s1_count),
      .pos      (s1_pos),
      .value    (lane_value[l]),
      .dest     (lane_dest[l])
    );
  end

  pixnorm_merge #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .LANE_W       (LANE_W)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .s3_valid   (s3_valid),
    .meta       (s3_meta),
    .k_last     (s3_k_last),
    .value      (lane_value),
    .dest       (lane_dest),
    .s3_done    (s3_done),
    .result_out (result_out)
  );

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel beat not held in the input stage");
  a_done_needs_item: assert property (@(posedge clk) disable iff (rst)
    s3_done |-> s3_valid)
    else $error("merge finished a pixel that is not present");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid)
    else $error("stalled pixel dropped from the input stage");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the pixel normaliser: directed and random pixels against a predictor.
`timescale 1ns / 1ps

module testbench;
  import pixnorm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixnorm_in_if  pixel_in();
  pixnorm_out_if result_out();

  pixel_normalize_hwc_to_chw_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_in),
    .result_out (result_out)
  );

  // Mirror of the register file and of the raster counter.
  logic [CFG_CHAN_W-1:0] mirror_tensor_ch;
  logic [CFG_CHAN_W-1:0] mirror_source_ch;
  logic [CFG_SIDE_W-1:0] mirror_width;
  logic [CFG_SIDE_W-1:0] mirror_height;
  logic [CFG_DATA_W-1:0] mirror_norm [4];
  int unsigned           raster_pos;

  result_t planes_due[$];
  result_t head_due;
  int      mismatch_count = 0;
  int      src_idle_pct = 31;
  int      sink_idle_pct = 69;
  int      hold_req = 0;
  int      hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned side_val(input logic [CFG_SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > 2048) return 2048;
    return v;
  endfunction

  // Works out the plane values that one pixel produces and queues them.
  task automatic compute_planes(input pix_t p);
    int unsigned       count;
    int unsigned       pos;
    logic              last_img;
    logic              bad;
    logic [7:0]        chan_byte [4];
    logic signed [31:0] scale;
    logic signed [31:0] offset;
    longint            v;
    longint unsigned   dest;
    result_t           r;
    count = side_val(mirror_width) * side_val(mirror_height);
    if (raster_pos >= count) raster_pos = 0;
    pos = raster_pos;
    last_img = (pos == count - 1);
    bad = mirror_tensor_ch == 0 || mirror_tensor_ch > 4 || mirror_source_ch == 0 ||
          mirror_source_ch > 4 || mirror_source_ch == 2 || mirror_tensor_ch > mirror_source_ch;
    chan_byte[0] = p.pixel_byte0;
    chan_byte[1] = p.pixel_byte1;
    chan_byte[2] = p.pixel_byte2;
    chan_byte[3] = p.pixel_byte3;
    if (bad) begin
      r = '0;
      r.dest_index = pos[DEST_W-1:0];
      r.last_in_pixel = 1'b1;
      r.last_in_image = last_img;
      r.status = 1'b1;
      planes_due.push_back(r);
    end else begin
      for (int c = 0; c < mirror_tensor_ch; c++) begin
        scale = mirror_norm[c][63:32];
        offset = mirror_norm[c][31:0];
        v = longint'(chan_byte[c]) * longint'(scale) + longint'(offset);
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        dest = longint'(c) * count + pos;
        r.norm_value = v[31:0];
        r.dest_index = dest[DEST_W-1:0];
        r.plane = c[PLANE_W-1:0];
        r.last_in_pixel = (c + 1 == mirror_tensor_ch);
        r.last_in_image = last_img;
        r.status = 1'b0;
        planes_due.push_back(r);
      end
    end
    raster_pos = (pos + 1 >= count) ? 0 : pos + 1;
  endtask

  // Offers one pixel, entered and left at a falling edge.
  task automatic push_pixel(input pix_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_in.valid = 1'b0;
      @(negedge clk);
    end
    pixel_in.data = p;
    pixel_in.valid = 1'b1;
    do @(posedge clk); while (pixel_in.ready !== 1'b1);
    compute_planes(p);
    @(negedge clk);
    pixel_in.valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      REG_TENSOR_CHANNELS: mirror_tensor_ch = value[CFG_CHAN_W-1:0];
      REG_SOURCE_CHANNELS: mirror_source_ch = value[CFG_CHAN_W-1:0];
      REG_IMAGE_WIDTH:     mirror_width = value[CFG_SIDE_W-1:0];
      REG_IMAGE_HEIGHT:    mirror_height = value[CFG_SIDE_W-1:0];
      REG_NORM_CHAN0:      mirror_norm[0] = value;
      REG_NORM_CHAN1:      mirror_norm[1] = value;
      REG_NORM_CHAN2:      mirror_norm[2] = value;
      default:             mirror_norm[3] = value;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Holds the sender back until every queued plane value has come out.
  task automatic wait_drained();
    while (planes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_channels(input logic [2:0] tensor_ch, input logic [2:0] source_ch);
    wait_drained();
    write_reg(REG_TENSOR_CHANNELS, 64'(tensor_ch));
    write_reg(REG_SOURCE_CHANNELS, 64'(source_ch));
  endtask

  task automatic set_image(input logic [11:0] w, input logic [11:0] h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 64'(w));
    write_reg(REG_IMAGE_HEIGHT, 64'(h));
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
      if (planes_due.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual %0h", $time, result_out.data);
        mismatch_count++;
      end else begin
        head_due = planes_due.pop_front();
        compare_field("norm_value", 64'(head_due.norm_value), 64'(result_out.data.norm_value));
        compare_field("dest_index", 64'(head_due.dest_index), 64'(result_out.data.dest_index));
        compare_field("plane", 64'(head_due.plane), 64'(result_out.data.plane));
        compare_field("last_in_pixel", 64'(head_due.last_in_pixel),
                      64'(result_out.data.last_in_pixel));
        compare_field("last_in_image", 64'(head_due.last_in_image),
                      64'(result_out.data.last_in_image));
        compare_field("status", 64'(head_due.status), 64'(result_out.data.status));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic test_default_setup();
    push_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    push_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_pixel('{8'h5A, 8'hA5, 8'h0F, 8'hF0});
  endtask

  task automatic test_channel_settings();
    set_channels(3'd4, 3'd4);
    push_pixel('{8'h12, 8'h34, 8'h56, 8'h78});
    set_channels(3'd1, 3'd1);
    push_pixel('{8'hFE, 8'h01, 8'h80, 8'h7F});
    set_channels(3'd2, 3'd3);
    push_pixel('{8'h81, 8'h42, 8'h24, 8'h18});
    // The rest are invalid settings: two source channels, zero planes,
    // more planes than source channels, and counts out of range.
    set_channels(3'd2, 3'd2);
    push_pixel('{8'h11, 8'h22, 8'h33, 8'h44});
    set_channels(3'd0, 3'd3);
    push_pixel('{8'hAA, 8'hBB, 8'hCC, 8'hDD});
    set_channels(3'd4, 3'd3);
    push_pixel('{8'h01, 8'h02, 8'h03, 8'h04});
    set_channels(3'd5, 3'd5);
    push_pixel('{8'hF1, 8'hF2, 8'hF3, 8'hF4});
    set_channels(3'd7, 3'd0);
    push_pixel('{8'h99, 8'h66, 8'h33, 8'hCC});
  endtask

  task automatic test_saturation();
    set_channels(3'd4, 3'd4);
    write_reg(REG_NORM_CHAN0, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(REG_NORM_CHAN1, 64'h8000_0000_8000_0000);
    write_reg(REG_NORM_CHAN2, 64'h0000_0000_8000_0000);
    write_reg(REG_NORM_CHAN3, 64'hFFFF_FFFF_0000_0000);
    push_pixel('{8'hFF, 8'hFF, 8'hFF, 8'h00});
    push_pixel('{8'h00, 8'h00, 8'h00, 8'hFF});
    push_pixel('{8'h01, 8'h80, 8'h7F, 8'hFE});
  endtask

  task automatic test_raster_wrap();
    set_image(12'd2, 12'd2);
    write_reg(REG_NORM_CHAN0, 64'h0000_0474_FFFD_E000);
    repeat (6) push_pixel(pix_t'($urandom));
    // The counter now sits past the end of a one-pixel image and restarts.
    set_image(12'd1, 12'd1);
    push_pixel(pix_t'($urandom));
    // Zero sides count as one, oversized sides as the maximum.
    set_image(12'd0, 12'd4095);
    repeat (2) push_pixel(pix_t'($urandom));
    set_image(12'd4095, 12'd0);
    push_pixel(pix_t'($urandom));
  endtask

  task automatic test_output_hold_off();
    int saved_src;
    wait_drained();
    saved_src = src_idle_pct;
    src_idle_pct = 0;
    set_image(12'd5, 12'd3);
    @(posedge clk);
    hold_req = 250;
    @(negedge clk);
    repeat (40) push_pixel(pix_t'($urandom));
    wait_drained();
    repeat (10) push_pixel(pix_t'($urandom));
    src_idle_pct = saved_src;
  endtask

  task automatic pick_setup();
    logic [2:0]  tensor_ch;
    logic [2:0]  source_ch;
    logic [11:0] w;
    logic [11:0] h;
    logic [31:0] scale;
    logic [31:0] offset;
    int          pick;
    wait_drained();
    if ($urandom_range(9) == 0) begin
      tensor_ch = 3'($urandom_range(7));
      source_ch = 3'($urandom_range(7));
    end else begin
      pick = $urandom_range(2);
      source_ch = (pick == 0) ? 3'd1 : (pick == 1) ? 3'd3 : 3'd4;
      tensor_ch = 3'($urandom_range(source_ch, 1));
    end
    write_reg(REG_TENSOR_CHANNELS, 64'(tensor_ch));
    write_reg(REG_SOURCE_CHANNELS, 64'(source_ch));
    w = ($urandom_range(19) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(6, 1));
    h = ($urandom_range(19) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(6, 1));
    write_reg(REG_IMAGE_WIDTH, 64'(w));
    write_reg(REG_IMAGE_HEIGHT, 64'(h));
    for (int c = 0; c < 4; c++) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        scale = $urandom;
        offset = $urandom;
      end else if (pick == 1) begin
        scale = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        offset = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        // Realistic mean and deviation: small positive scale, negative offset.
        scale = $urandom_range(4096);
        offset = -32'($urandom_range(200000));
      end
      write_reg(cfg_reg_e'(REG_NORM_CHAN0 + c), {scale, offset});
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (4) begin
      pick_setup();
      repeat (20) push_pixel(pix_t'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_TENSOR_CHANNELS;
    cfg_data = '0;
    pixel_in.valid = 1'b0;
    pixel_in.data = '0;
    result_out.ready = 1'b0;
    mirror_tensor_ch = CHAN_RESET;
    mirror_source_ch = CHAN_RESET;
    mirror_width = SIDE_RESET;
    mirror_height = SIDE_RESET;
    for (int i = 0; i < 4; i++) mirror_norm[i] = NORM_RESET;
    raster_pos = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_default_setup();
    test_channel_settings();
    test_saturation();
    test_raster_wrap();
    test_output_hold_off();
    test_random_traffic(31, 69);
    test_random_traffic(69, 31);
    test_random_traffic(0, 0);

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pixnorm_pkg.sv
rtl/pixnorm_in_if.sv
rtl/pixnorm_out_if.sv
rtl/pixnorm_lane.sv
rtl/pixnorm_merge.sv
rtl/pixel_normalize_hwc_to_chw_top.sv
tb/testbench.sv
